/* hw/rtl/sacl_pkg.sv */
// Shared types and constants for the set-associative LRU cache model.
// Used by set_assoc_cache_lru_model; depends on nothing.
`default_nettype none

package sacl_pkg;

  // Field widths fixed by the transaction format.
  localparam int unsigned OpW      = 2;
  localparam int unsigned AddrW    = 64;
  localparam int unsigned TagW     = 64;
  localparam int unsigned AgeW     = 32;
  localparam int unsigned CntW     = 32;

  // Configuration port.
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 6;
  localparam int unsigned SetBitsW = 4;
  localparam int unsigned WaysW    = 4;
  localparam int unsigned OffBitsW = 6;

  localparam logic [CfgIdxW-1:0] CfgSetIndexBits    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWaysInUse       = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgBlockOffsetBits = 2'd2;

  localparam logic [SetBitsW-1:0] SetBitsRst = 4'd4;
  localparam logic [WaysW-1:0]    WaysRst    = 4'd1;
  localparam logic [OffBitsW-1:0] OffBitsRst = 6'd4;

  // Operation codes of an input transaction.
  localparam logic [OpW-1:0] OpLoad   = 2'd0;
  localparam logic [OpW-1:0] OpStore  = 2'd1;
  localparam logic [OpW-1:0] OpModify = 2'd2;
  localparam logic [OpW-1:0] OpFetch  = 2'd3;

  // Default geometry of the storage.
  localparam int unsigned MaxSetBitsDef = 8;
  localparam int unsigned MaxWaysDef    = 8;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [AddrW-1:0] address;
  } in_t;

  typedef struct packed {
    logic            hit;
    logic            miss;
    logic            evicted;
    logic            last;
    logic [CntW-1:0] hit_total;
    logic [CntW-1:0] miss_total;
    logic [CntW-1:0] evict_total;
  } out_t;

endpackage

`default_nettype wire

/* hw/rtl/sacl_ram.sv */
// Generic single-port synchronous RAM with a registered read.
// Stand-alone; used by set_assoc_cache_lru_model for the set rows.
`default_nettype none

module sacl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write at the address, read the old contents into the output register.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/set_assoc_cache_lru_model.sv */
// Set-associative cache model with LRU replacement and saturating totals.
// Depends on sacl_pkg and sacl_ram.
//
// Usage: the input channel (in_valid_i, in_stall_o, in_data_i) takes one
// trace transaction: an operation and a byte address. Load and store cause one
// access, modify causes two accesses to the same address, instruction fetch
// causes none. Every access produces one transaction on the output channel
// (out_valid_o, out_stall_i, out_data_o) with hit, miss and eviction flags,
// a last flag on the final access of the input transaction, and the totals.
// Each set is one row of a single-port RAM holding all ways (valid, tag, age).
// An access accepts and reads the row, compares the tags, then picks the
// victim and writes the row back. The second access of a modify rereads the
// row after the write-back. An instruction fetch is absorbed without an access.
// After reset the block sweeps all 2**MaxSetBits sets of the RAM clear (256 by
// default), one set per cycle, and holds in_stall_o high meanwhile.
// The output register lets a new transaction be accepted while a result waits;
// when the receiver stalls with a result pending, the block waits before the
// write-back of the next access. The configuration port writes at any time,
// but is meant to change only while the block is idle.
`default_nettype none

module set_assoc_cache_lru_model #(
  parameter int unsigned MaxSetBits = sacl_pkg::MaxSetBitsDef,
  parameter int unsigned MaxWays    = sacl_pkg::MaxWaysDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Configuration write port.
  input  wire logic                          cfg_we_i,
  input  wire logic [sacl_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [sacl_pkg::CfgDataW-1:0] cfg_data_i,
  // Input channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire sacl_pkg::in_t                 in_data_i,
  // Output channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output sacl_pkg::out_t                     out_data_o
);

  localparam int unsigned Depth   = 1 << MaxSetBits;
  localparam int unsigned SetAw   = (MaxSetBits > 0) ? MaxSetBits : 1;
  localparam int unsigned WayW    = (MaxWays > 1) ? $clog2(MaxWays) : 1;
  localparam int unsigned WayCntW = $clog2(MaxWays + 1);
  localparam int unsigned TreeN   = 1 << WayW;
  localparam int unsigned TagOff  = MaxWays;
  localparam int unsigned AgeOff  = MaxWays * (1 + sacl_pkg::TagW);
  localparam int unsigned RowW    = MaxWays * (1 + sacl_pkg::TagW + sacl_pkg::AgeW);

  localparam logic [2:0] StClear = 3'd0;
  localparam logic [2:0] StIdle  = 3'd1;
  localparam logic [2:0] StRead  = 3'd2;
  localparam logic [2:0] StEval  = 3'd3;
  localparam logic [2:0] StIssue = 3'd4;

  // Control state.
  logic [2:0]                     state_q, state_d;
  logic [SetAw-1:0]               clr_cnt_q, clr_cnt_d;
  logic                           pend_q, pend_d;
  logic                           last_q, last_d;
  logic                           out_valid_q, out_valid_d;
  logic [sacl_pkg::CntW-1:0]      stamp_q, stamp_d;
  logic [sacl_pkg::CntW-1:0]      hits_q, hits_d;
  logic [sacl_pkg::CntW-1:0]      misses_q, misses_d;
  logic [sacl_pkg::CntW-1:0]      evicts_q, evicts_d;
  logic [sacl_pkg::SetBitsW-1:0]  set_bits_q;
  logic [sacl_pkg::WaysW-1:0]     ways_q;
  logic [sacl_pkg::OffBitsW-1:0]  off_bits_q;

  // Payload state.
  logic [SetAw-1:0]               acc_set_q, acc_set_d;
  logic [sacl_pkg::TagW-1:0]      acc_tag_q, acc_tag_d;
  logic                           hit_q;
  logic [WayW-1:0]                hit_way_q;
  logic                           inv_q;
  logic [WayW-1:0]                inv_way_q;
  sacl_pkg::out_t                 out_q, out_d;

  // RAM port.
  logic                           ram_we;
  logic [SetAw-1:0]               ram_addr;
  logic [RowW-1:0]                ram_wdata;
  logic [RowW-1:0]                ram_rdata;

  // Decoded row and helpers.
  logic [MaxWays-1:0]             row_valid;
  logic [sacl_pkg::TagW-1:0]      row_tag [MaxWays];
  logic [sacl_pkg::AgeW-1:0]      row_age [MaxWays];
  logic [WayCntW-1:0]             ways_eff;
  logic [MaxWays-1:0]             way_en;
  logic [sacl_pkg::SetBitsW-1:0]  sb_eff;
  logic [sacl_pkg::AddrW-1:0]     set_full;
  logic [SetAw-1:0]               in_set;
  logic [6:0]                     tag_shamt;
  logic [sacl_pkg::TagW-1:0]      in_tag;
  logic                           rd_hit;
  logic [WayW-1:0]                rd_hit_way;
  logic                           rd_inv;
  logic [WayW-1:0]                rd_inv_way;
  logic [WayW-1:0]                lru_way;
  logic [WayW-1:0]                victim;
  logic [RowW-1:0]                new_row;
  logic                           accept;
  logic                           can_emit;
  logic                           emit;

  sacl_ram #(
    .Width (RowW),
    .Depth (Depth),
    .AddrW (SetAw)
  ) u_rows (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Configuration registers; writes beyond the register list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= sacl_pkg::SetBitsRst;
      ways_q     <= sacl_pkg::WaysRst;
      off_bits_q <= sacl_pkg::OffBitsRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sacl_pkg::CfgSetIndexBits:    set_bits_q <= cfg_data_i[sacl_pkg::SetBitsW-1:0];
        sacl_pkg::CfgWaysInUse:       ways_q     <= cfg_data_i[sacl_pkg::WaysW-1:0];
        sacl_pkg::CfgBlockOffsetBits: off_bits_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective geometry: clamp set bits and associativity.
  always_comb begin
    if (int'(set_bits_q) > MaxSetBits) begin
      sb_eff = sacl_pkg::SetBitsW'(MaxSetBits);
    end else begin
      sb_eff = set_bits_q;
    end
    if (ways_q == '0) begin
      ways_eff = WayCntW'(1);
    end else if (int'(ways_q) > MaxWays) begin
      ways_eff = WayCntW'(MaxWays);
    end else begin
      ways_eff = WayCntW'(ways_q);
    end
    for (int w = 0; w < MaxWays; w++) begin
      way_en[w] = (w < int'(ways_eff));
    end
  end

  // Split the incoming address into set index and tag.
  always_comb begin
    set_full  = in_data_i.address >> off_bits_q;
    set_full  = set_full & ((64'd1 << sb_eff) - 64'd1);
    in_set    = set_full[SetAw-1:0];
    tag_shamt = {1'b0, off_bits_q} + {3'b000, sb_eff};
    if (tag_shamt[6]) begin
      in_tag = '0;
    end else begin
      in_tag = in_data_i.address >> tag_shamt[5:0];
    end
  end

  // Unpack the row read from the RAM.
  always_comb begin
    row_valid = ram_rdata[MaxWays-1:0];
    for (int w = 0; w < MaxWays; w++) begin
      row_tag[w] = ram_rdata[TagOff + w*sacl_pkg::TagW +: sacl_pkg::TagW];
      row_age[w] = ram_rdata[AgeOff + w*sacl_pkg::AgeW +: sacl_pkg::AgeW];
    end
  end

  // Tag compare and first invalid way; the lowest way wins.
  always_comb begin
    rd_hit     = 1'b0;
    rd_hit_way = '0;
    rd_inv     = 1'b0;
    rd_inv_way = '0;
    for (int w = MaxWays - 1; w >= 0; w--) begin
      if (way_en[w] && row_valid[w] && (row_tag[w] == acc_tag_q)) begin
        rd_hit     = 1'b1;
        rd_hit_way = WayW'(w);
      end
      if (way_en[w] && !row_valid[w]) begin
        rd_inv     = 1'b1;
        rd_inv_way = WayW'(w);
      end
    end
  end

  // Least recently used way by a compare tree; ties go to the lower way.
  always_comb begin
    logic [sacl_pkg::AgeW-1:0] tv [TreeN];
    logic [WayW-1:0]           ti [TreeN];
    logic                      tok [TreeN];
    for (int i = 0; i < TreeN; i++) begin
      if (i < MaxWays) begin
        tv[i]  = row_age[i];
        tok[i] = way_en[i];
      end else begin
        tv[i]  = '0;
        tok[i] = 1'b0;
      end
      ti[i] = WayW'(i);
    end
    for (int s = 1; s < TreeN; s = s * 2) begin
      for (int i = 0; i < TreeN; i = i + 2 * s) begin
        if (tok[i+s] && (!tok[i] || (tv[i+s] < tv[i]))) begin
          tv[i]  = tv[i+s];
          ti[i]  = ti[i+s];
          tok[i] = 1'b1;
        end
      end
    end
    lru_way = ti[0];
  end

  // Build the updated row: refresh the age on a hit, fill the victim on a miss.
  always_comb begin
    victim  = inv_q ? inv_way_q : lru_way;
    new_row = ram_rdata;
    stamp_d = stamp_q + 32'd1;
    for (int w = 0; w < MaxWays; w++) begin
      if (hit_q && (hit_way_q == WayW'(w))) begin
        new_row[AgeOff + w*sacl_pkg::AgeW +: sacl_pkg::AgeW] = stamp_d;
      end
      if (!hit_q && (victim == WayW'(w))) begin
        new_row[w] = 1'b1;
        new_row[TagOff + w*sacl_pkg::TagW +: sacl_pkg::TagW] = acc_tag_q;
        new_row[AgeOff + w*sacl_pkg::AgeW +: sacl_pkg::AgeW] = stamp_d;
      end
    end
  end

  // Handshake and RAM port control.
  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && !in_stall_o;
  assign can_emit   = !out_valid_q || !out_stall_i;
  assign emit       = (state_q == StEval) && can_emit;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = acc_set_q;
    ram_wdata = new_row;
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_addr  = clr_cnt_q;
      ram_wdata = '0;
    end else if (state_q == StIdle) begin
      ram_addr  = in_set;
    end else if (emit) begin
      ram_we    = 1'b1;
    end
  end

  // Sequencer: clear sweep, accept, read, evaluate and write back, reissue for modify.
  always_comb begin
    state_d   = state_q;
    clr_cnt_d = clr_cnt_q;
    pend_d    = pend_q;
    last_d    = last_q;
    acc_set_d = acc_set_q;
    acc_tag_d = acc_tag_q;
    unique case (state_q)
      StClear: begin
        clr_cnt_d = clr_cnt_q + SetAw'(1);
        if (clr_cnt_q == SetAw'(Depth - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          acc_set_d = in_set;
          acc_tag_d = in_tag;
          unique case (in_data_i.op)
            sacl_pkg::OpLoad, sacl_pkg::OpStore: begin
              pend_d  = 1'b0;
              last_d  = 1'b1;
              state_d = StRead;
            end
            sacl_pkg::OpModify: begin
              pend_d  = 1'b1;
              last_d  = 1'b0;
              state_d = StRead;
            end
            sacl_pkg::OpFetch: ;
            default: ;
          endcase
        end
      end
      StRead: begin
        state_d = StEval;
      end
      StEval: begin
        if (can_emit) begin
          if (pend_q) begin
            pend_d  = 1'b0;
            last_d  = 1'b1;
            state_d = StIssue;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StIssue: begin
        state_d = StRead;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Totals and the result transaction.
  always_comb begin
    hits_d      = hits_q;
    misses_d    = misses_q;
    evicts_d    = evicts_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    if (emit) begin
      if (hit_q) begin
        hits_d = (hits_q == '1) ? hits_q : hits_q + 32'd1;
      end else begin
        misses_d = (misses_q == '1) ? misses_q : misses_q + 32'd1;
        if (!inv_q) begin
          evicts_d = (evicts_q == '1) ? evicts_q : evicts_q + 32'd1;
        end
      end
      out_valid_d       = 1'b1;
      out_d.hit         = hit_q;
      out_d.miss        = !hit_q;
      out_d.evicted     = !hit_q && !inv_q;
      out_d.last        = last_q;
      out_d.hit_total   = hits_d;
      out_d.miss_total  = misses_d;
      out_d.evict_total = evicts_d;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      stamp_q     <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (emit) begin
        stamp_q <= stamp_d;
      end
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_set_q <= acc_set_d;
    acc_tag_q <= acc_tag_d;
    out_q     <= out_d;
    if (state_q == StRead) begin
      hit_q     <= rd_hit;
      hit_way_q <= rd_hit_way;
      inv_q     <= rd_inv;
      inv_way_q <= rd_inv_way;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
